FILE: hw/rtl/dvru_pkg.sv
// dvru_pkg: shared types, result codes and defaults for the distance-vector route update block
// no dependencies; imported by every module under hw/rtl

package dvru_pkg;

  localparam int DEF_NODES  = 8;
  localparam int DEF_ROUTES = 32;

  localparam logic [3:0] HOP_MAX = 4'd15;

  // result status codes
  localparam logic [1:0] RES_UNCHANGED = 2'd0;
  localparam logic [1:0] RES_IMPROVED  = 2'd1;
  localparam logic [1:0] RES_ADDED     = 2'd2;
  localparam logic [1:0] RES_DROPPED   = 2'd3;

  typedef struct packed {
    logic [2:0] router;
    logic [2:0] neighbour;
    logic [7:0] network_id;
    logic [3:0] advertised_hops;
  } in_item_t;

  typedef struct packed {
    logic [1:0] status;
    logic [2:0] stored_next_hop;
    logic [3:0] stored_hops;
  } out_item_t;

  // one routing table entry as held in the route memory
  typedef struct packed {
    logic [7:0] network;
    logic [2:0] next_hop;
    logic [3:0] hop_count;
  } route_entry_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_COUNT,
    ST_SCAN
  } dvru_state_t;

endpackage

FILE: hw/rtl/dvru_ram.sv
// dvru_ram: single-clock memory, one write port and one read port with registered read data
// depends on dvru_pkg (imported for the DEF_NODES and DEF_ROUTES default of DEPTH)

module dvru_ram
  import dvru_pkg::*;
#(
  parameter int WIDTH = 15,
  parameter int DEPTH = DEF_NODES * DEF_ROUTES,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic             re,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

FILE: hw/rtl/dvru_ctrl.sv
// dvru_ctrl: sequencer for one route update: count lookup, table scan, write-back and result
// depends on dvru_pkg; drives the route memory and the entry count memory

module dvru_ctrl
  import dvru_pkg::*;
#(
  parameter int NODES  = DEF_NODES,
  parameter int ROUTES = DEF_ROUTES,
  localparam int NODE_W = $clog2(NODES),
  localparam int ADDR_W = $clog2(NODES * ROUTES),
  localparam int CNT_W  = $clog2(ROUTES + 1),
  localparam int ENT_W  = $bits(route_entry_t)
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              start,
  output logic              busy,
  input  in_item_t          in_data,
  output logic              out_valid,
  output out_item_t         out_data,
  output logic              rt_we,
  output logic [ADDR_W-1:0] rt_waddr,
  output logic [ENT_W-1:0]  rt_wdata,
  output logic              rt_re,
  output logic [ADDR_W-1:0] rt_raddr,
  input  logic [ENT_W-1:0]  rt_rdata,
  output logic              cnt_we,
  output logic [NODE_W-1:0] cnt_waddr,
  output logic [CNT_W-1:0]  cnt_wdata,
  output logic              cnt_re,
  output logic [NODE_W-1:0] cnt_raddr,
  input  logic [CNT_W-1:0]  cnt_rdata
);

  dvru_state_t       state_r, state_nxt;
  in_item_t          req_r, req_nxt;
  logic [NODE_W-1:0] node_r, node_nxt;
  logic [ADDR_W-1:0] base_r, base_nxt;
  logic [3:0]        cost_r, cost_nxt;
  logic [CNT_W-1:0]  cnt_r, cnt_nxt;
  logic [CNT_W-1:0]  iss_r, iss_nxt;
  logic [CNT_W-1:0]  pidx_r, pidx_nxt;
  logic              pend_r, pend_nxt;
  logic [NODES-1:0]  cnt_vld_r, cnt_vld_nxt;
  logic              out_valid_r, out_valid_nxt;
  out_item_t         out_data_r, out_data_nxt;

  logic              acc;
  logic              in_range;
  logic [NODE_W-1:0] in_node;
  logic [3:0]        in_cost;
  route_entry_t      rd_ent;
  route_entry_t      wr_ent;
  logic              hit;
  logic              miss;
  logic              improve;
  logic              full;

  assign acc      = start && (state_r == ST_IDLE);
  assign in_range = (32'(in_data.router) < NODES);
  assign in_node  = NODE_W'(in_data.router);
  assign in_cost  = (in_data.advertised_hops == HOP_MAX) ? HOP_MAX :
                    (in_data.advertised_hops + 4'd1);

  assign rd_ent  = route_entry_t'(rt_rdata);
  assign hit     = (state_r == ST_SCAN) && pend_r && (rd_ent.network == req_r.network_id);
  assign miss    = (state_r == ST_SCAN) && !pend_r && (iss_r == cnt_r);
  assign improve = (rd_ent.hop_count > cost_r);
  assign full    = (cnt_r == CNT_W'(ROUTES));

  assign wr_ent.network   = req_r.network_id;
  assign wr_ent.next_hop  = req_r.neighbour;
  assign wr_ent.hop_count = cost_r;

  // next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE: begin
        if (acc && in_range) begin
          state_nxt = ST_COUNT;
        end
      end
      ST_COUNT: begin
        state_nxt = ST_SCAN;
      end
      ST_SCAN: begin
        if (hit || miss) begin
          state_nxt = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  // datapath and memory control
  always_comb begin
    req_nxt       = req_r;
    node_nxt      = node_r;
    base_nxt      = base_r;
    cost_nxt      = cost_r;
    cnt_nxt       = cnt_r;
    iss_nxt       = iss_r;
    pidx_nxt      = pidx_r;
    pend_nxt      = pend_r;
    cnt_vld_nxt   = cnt_vld_r;
    out_valid_nxt = 1'b0;
    out_data_nxt  = out_data_r;
    rt_we         = 1'b0;
    rt_waddr      = base_r + ADDR_W'(pidx_r);
    rt_wdata      = ENT_W'(wr_ent);
    rt_re         = 1'b0;
    rt_raddr      = base_r + ADDR_W'(iss_r);
    cnt_we        = 1'b0;
    cnt_waddr     = node_r;
    cnt_wdata     = cnt_r + CNT_W'(1);
    cnt_re        = 1'b0;
    cnt_raddr     = in_node;

    unique case (state_r)
      ST_IDLE: begin
        if (acc) begin
          req_nxt  = in_data;
          node_nxt = in_node;
          base_nxt = ADDR_W'(in_node * ROUTES);
          cost_nxt = in_cost;
          if (in_range) begin
            cnt_re = 1'b1;
          end else begin
            out_valid_nxt = 1'b1;
            out_data_nxt  = '{status: RES_DROPPED, stored_next_hop: 3'd0, stored_hops: 4'd0};
          end
        end
      end
      ST_COUNT: begin
        // a router never appended to reads as an empty table
        cnt_nxt  = cnt_vld_r[node_r] ? cnt_rdata : '0;
        iss_nxt  = '0;
        pend_nxt = 1'b0;
      end
      ST_SCAN: begin
        // issue one read a cycle, compare the entry read the cycle before
        if (iss_r < cnt_r) begin
          rt_re    = 1'b1;
          iss_nxt  = iss_r + CNT_W'(1);
          pend_nxt = 1'b1;
          pidx_nxt = iss_r;
        end else begin
          pend_nxt = 1'b0;
        end
        if (hit) begin
          out_valid_nxt = 1'b1;
          if (improve) begin
            rt_we        = 1'b1;
            out_data_nxt = '{status: RES_IMPROVED, stored_next_hop: req_r.neighbour,
                             stored_hops: cost_r};
          end else begin
            out_data_nxt = '{status: RES_UNCHANGED, stored_next_hop: rd_ent.next_hop,
                             stored_hops: rd_ent.hop_count};
          end
        end else if (miss) begin
          out_valid_nxt = 1'b1;
          if (full) begin
            out_data_nxt = '{status: RES_DROPPED, stored_next_hop: 3'd0, stored_hops: 4'd0};
          end else begin
            rt_we                = 1'b1;
            rt_waddr             = base_r + ADDR_W'(cnt_r);
            cnt_we               = 1'b1;
            cnt_vld_nxt[node_r]  = 1'b1;
            out_data_nxt = '{status: RES_ADDED, stored_next_hop: req_r.neighbour,
                             stored_hops: cost_r};
          end
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      pend_r      <= 1'b0;
      cnt_vld_r   <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      pend_r      <= pend_nxt;
      cnt_vld_r   <= cnt_vld_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    req_r      <= req_nxt;
    node_r     <= node_nxt;
    base_r     <= base_nxt;
    cost_r     <= cost_nxt;
    cnt_r      <= cnt_nxt;
    iss_r      <= iss_nxt;
    pidx_r     <= pidx_nxt;
    out_data_r <= out_data_nxt;
  end

  assign busy      = (state_r != ST_IDLE);
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

endmodule

FILE: hw/rtl/distance_vector_route_update.sv
// distance_vector_route_update: top level of the distance-vector route update block
// depends on dvru_pkg, dvru_ram and dvru_ctrl
//
//   channel  | ports                      | handshake
//   ---------+----------------------------+--------------------------------------
//   input    | start, busy, in_data       | transfer when start high, busy low
//   result   | out_valid, out_data        | one-cycle strobe, cannot be held off
//
// search: an advertisement found at table position k finishes once entries 0 to k have
//   been read; an absent one in a table of n entries reads all n first (none when the
//   table is empty), at most ROUTES;
//   a router index of NODES or above is answered without a table search.
//   the search time is set by the table scan, one route memory read per cycle.
// reset: rst_n is synchronous; it clears the sequencer and all entry counts,
//   table memory contents are not cleared and are only read below the count.
// stalls: the receiver cannot stall; the next transfer may be taken while the
//   previous result is on the out_ ports.

module distance_vector_route_update
  import dvru_pkg::*;
#(
  parameter int NODES  = DEF_NODES,
  parameter int ROUTES = DEF_ROUTES
) (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      start,
  output logic      busy,
  input  in_item_t  in_data,
  output logic      out_valid,
  output out_item_t out_data
);

  localparam int NODE_W = $clog2(NODES);
  localparam int ADDR_W = $clog2(NODES * ROUTES);
  localparam int CNT_W  = $clog2(ROUTES + 1);
  localparam int ENT_W  = $bits(route_entry_t);

  // route memory port
  logic              rt_we;
  logic [ADDR_W-1:0] rt_waddr;
  logic [ENT_W-1:0]  rt_wdata;
  logic              rt_re;
  logic [ADDR_W-1:0] rt_raddr;
  logic [ENT_W-1:0]  rt_rdata;

  // entry count memory port
  logic              cnt_we;
  logic [NODE_W-1:0] cnt_waddr;
  logic [CNT_W-1:0]  cnt_wdata;
  logic              cnt_re;
  logic [NODE_W-1:0] cnt_raddr;
  logic [CNT_W-1:0]  cnt_rdata;

  // all routing tables, router r owns entries r*ROUTES .. r*ROUTES+ROUTES-1
  dvru_ram #(
    .WIDTH (ENT_W),
    .DEPTH (NODES * ROUTES)
  ) u_route_mem (
    .clk   (clk),
    .we    (rt_we),
    .waddr (rt_waddr),
    .wdata (rt_wdata),
    .re    (rt_re),
    .raddr (rt_raddr),
    .rdata (rt_rdata)
  );

  // per-router entry count, valid bits for reset live in the sequencer
  dvru_ram #(
    .WIDTH (CNT_W),
    .DEPTH (NODES)
  ) u_count_mem (
    .clk   (clk),
    .we    (cnt_we),
    .waddr (cnt_waddr),
    .wdata (cnt_wdata),
    .re    (cnt_re),
    .raddr (cnt_raddr),
    .rdata (cnt_rdata)
  );

  dvru_ctrl #(
    .NODES  (NODES),
    .ROUTES (ROUTES)
  ) u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (start),
    .busy      (busy),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_data  (out_data),
    .rt_we     (rt_we),
    .rt_waddr  (rt_waddr),
    .rt_wdata  (rt_wdata),
    .rt_re     (rt_re),
    .rt_raddr  (rt_raddr),
    .rt_rdata  (rt_rdata),
    .cnt_we    (cnt_we),
    .cnt_waddr (cnt_waddr),
    .cnt_wdata (cnt_wdata),
    .cnt_re    (cnt_re),
    .cnt_raddr (cnt_raddr),
    .cnt_rdata (cnt_rdata)
  );

  // table writes only happen on the cycle that produces the result
  a_write_with_result: assert property (@(posedge clk) disable iff (!rst_n)
    rt_we |=> out_valid)
    else $error("route write without a result");

  // an append always writes the route entry together with the count
  a_count_with_entry: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_we |-> rt_we)
    else $error("count written without a route entry");

  // an added route is reported only after the count was bumped
  a_added_bumps_count: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && (out_data.status == RES_ADDED)) |-> $past(cnt_we))
    else $error("added route reported without count update");

  // a transfer either starts a search or is answered right away
  a_transfer_progress: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy) |=> (busy || out_valid))
    else $error("transfer dropped without a result");

endmodule
